[src/ftq_pkg.sv]
package ftq_pkg;

    localparam int ENTRIES   = 64;
    localparam int TIME_BITS = 32;
    localparam int ENTRY_AW  = $clog2(ENTRIES);
    localparam int ID_W      = 6;
    localparam int LINK_W    = 7;
    localparam int COUNT_W   = ENTRY_AW + 1;

    localparam logic [LINK_W-1:0] NIL_LINK = 7'h7f;

    typedef logic [2:0]           op_t;
    typedef logic [1:0]           kind_t;
    typedef logic [LINK_W-1:0]    link_t;
    typedef logic [TIME_BITS-1:0] tick_t;

    localparam op_t OP_START    = 3'd0;
    localparam op_t OP_STOP     = 3'd1;
    localparam op_t OP_RESTART  = 3'd2;
    localparam op_t OP_TICK     = 3'd3;
    localparam op_t OP_FLUSH    = 3'd4;
    localparam op_t OP_CLEAR    = 3'd5;
    localparam op_t OP_QUERY    = 3'd6;
    localparam op_t OP_RESERVED = 3'd7;

    localparam kind_t KIND_ACK     = 2'd0;
    localparam kind_t KIND_EXPIRED = 2'd1;
    localparam kind_t KIND_QUERY   = 2'd2;

endpackage

[src/ftq_req_if.sv]
interface ftq_req_if;
    import ftq_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [ID_W-1:0]      entry_id;
    logic [TIME_BITS-1:0] now_time;

    modport source (output valid, output operation, output entry_id, output now_time,
                    input ready);
    modport sink   (input valid, input operation, input entry_id, input now_time,
                    output ready);
endinterface

[src/ftq_rsp_if.sv]
interface ftq_rsp_if;
    import ftq_pkg::*;

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    logic [ID_W-1:0]      expired_id;
    logic                 entry_active;
    logic                 queue_nonempty;
    logic [TIME_BITS-1:0] next_deadline;
    logic                 last;

    modport source (output valid, output kind, output expired_id, output entry_active,
                    output queue_nonempty, output next_deadline, output last,
                    input ready);
    modport sink   (input valid, input kind, input expired_id, input entry_active,
                    input queue_nonempty, input next_deadline, input last,
                    output ready);
endinterface

[src/ftq_ram.sv]
module ftq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/fixed_timeout_queue_unit.sv]
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   operation, entry_id, now_time
// rsp       out  valid/ready   kind, expired_id, entry_active, queue_nonempty,
//                              next_deadline, last
// cfg       in   cfg_wr_en     cfg_wr_data (timeout_ticks)
//
// One item is taken at a time, and only in idle. Query, clear, an undefined code and
// stop of an idle entry go straight to the result; start passes ST_START; stop passes
// ST_STOP_RD, ST_STOP_UNL and, when the head moves, ST_STOP_HS to fetch its start time;
// restart runs stop, then ST_START (only ST_START when the entry is idle). Tick and flush
// walk from the head with ST_TICK_CHK, ST_TICK_NX, ST_TICK_HS per expired entry (no
// ST_TICK_HS when the list runs dry), one final check, then ST_EMIT_RD per stored result.
// rst_n clears the active flags, head and tail at once; the RAMs need no clearing.
// A stalled rsp holds the result; req.ready stays low until the last result goes.
module fixed_timeout_queue_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ftq_pkg::TIME_BITS-1:0]  cfg_wr_data,
    ftq_req_if.sink                        req,
    ftq_rsp_if.source                      rsp
);
    import ftq_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_STOP_RD  = 4'd1;
    localparam logic [3:0] ST_STOP_UNL = 4'd2;
    localparam logic [3:0] ST_STOP_HS  = 4'd3;
    localparam logic [3:0] ST_START    = 4'd4;
    localparam logic [3:0] ST_TICK_CHK = 4'd5;
    localparam logic [3:0] ST_TICK_NX  = 4'd6;
    localparam logic [3:0] ST_TICK_HS  = 4'd7;
    localparam logic [3:0] ST_EMIT_RD  = 4'd8;
    localparam logic [3:0] ST_EMIT_OUT = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [ENTRIES-1:0] active_reg, active_next;
    link_t              head_reg, head_next;
    link_t              tail_reg, tail_next;
    tick_t              head_start_reg, head_start_next;
    tick_t              timeout_reg;
    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    tick_t              now_reg;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    kind_t              res_kind_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic               res_act_reg;

    // RAM ports
    logic                next_we, prev_we, time_we, buf_we;
    logic [ENTRY_AW-1:0] next_waddr, prev_waddr, next_raddr;
    link_t               next_wdata, prev_wdata, next_rdata, prev_rdata;
    tick_t               time_rdata;
    logic [ID_W-1:0]     buf_rdata;

    logic                accept;
    logic                id_ok;
    link_t               id_link, cur_link, nx, pv;
    logic                expire;
    logic                append_ok;
    logic                out_last;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign id_ok     = ({1'b0, id_reg} < LINK_W'(ENTRIES));
    assign id_link   = {1'b0, id_reg};

    // The entry being unlinked: the queue head on a tick walk, else the addressed one.
    assign cur_link  = (state_reg == ST_TICK_NX) ? head_reg : id_link;
    assign nx        = (cur_link == tail_reg) ? NIL_LINK : next_rdata;
    assign pv        = (id_link == head_reg) ? NIL_LINK : prev_rdata;
    assign expire    = !head_reg[LINK_W-1] &&
                       ((op_reg == OP_FLUSH) || ((now_reg - head_start_reg) >= timeout_reg));
    assign append_ok = id_ok && !active_reg[id_reg[ENTRY_AW-1:0]];

    assign next_raddr = (state_reg == ST_TICK_CHK) ? head_reg[ENTRY_AW-1:0]
                                                  : id_reg[ENTRY_AW-1:0];

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = pv[ENTRY_AW-1:0];
        next_wdata = nx;
        prev_we    = 1'b0;
        prev_waddr = nx[ENTRY_AW-1:0];
        prev_wdata = pv;
        time_we    = 1'b0;
        buf_we     = 1'b0;
        case (state_reg)
            ST_STOP_UNL:
            begin
                next_we = !pv[LINK_W-1];
                prev_we = !nx[LINK_W-1];
            end
            ST_START:
            begin
                // link after the current tail
                next_we    = append_ok && !tail_reg[LINK_W-1];
                next_waddr = tail_reg[ENTRY_AW-1:0];
                next_wdata = id_link;
                prev_we    = append_ok;
                prev_waddr = id_reg[ENTRY_AW-1:0];
                prev_wdata = tail_reg;
                time_we    = append_ok;
            end
            ST_TICK_CHK:
            begin
                buf_we = expire;
            end
            default:
            begin
            end
        endcase
    end

    ftq_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    ftq_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (id_reg[ENTRY_AW-1:0]),
        .rdata (prev_rdata)
    );

    ftq_ram #(.WIDTH(TIME_BITS), .DEPTH(ENTRIES)) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (id_reg[ENTRY_AW-1:0]),
        .wdata (now_reg),
        .raddr (nx[ENTRY_AW-1:0]),
        .rdata (time_rdata)
    );

    // expired ids in list order, replayed once the walk is done
    ftq_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (n_reg[ENTRY_AW-1:0]),
        .wdata (head_reg[ID_W-1:0]),
        .raddr (k_reg[ENTRY_AW-1:0]),
        .rdata (buf_rdata)
    );

    assign out_last = (n_reg == '0) || (k_reg == n_reg - COUNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_start_next = head_start_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next = '0;
                    k_next = '0;
                    case (req.operation)
                        OP_START:
                        begin
                            state_next = ST_START;
                        end
                        OP_STOP, OP_RESTART:
                        begin
                            if (active_reg[req.entry_id[ENTRY_AW-1:0]])
                            begin
                                state_next = ST_STOP_RD;
                            end
                            else if (req.operation == OP_RESTART)
                            begin
                                state_next = ST_START;
                            end
                            else
                            begin
                                state_next = ST_EMIT_OUT;
                            end
                        end
                        OP_TICK, OP_FLUSH:
                        begin
                            state_next = ST_TICK_CHK;
                        end
                        OP_CLEAR:
                        begin
                            // drop everything silently
                            active_next = '0;
                            head_next   = NIL_LINK;
                            tail_next   = NIL_LINK;
                            state_next  = ST_EMIT_OUT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT_OUT;
                        end
                    endcase
                end
            end
            ST_STOP_RD:
            begin
                state_next = ST_STOP_UNL;
            end
            ST_STOP_UNL:
            begin
                active_next[id_reg[ENTRY_AW-1:0]] = 1'b0;
                if (tail_reg == id_link)
                begin
                    tail_next = pv;
                end
                if (head_reg == id_link)
                begin
                    head_next = nx;
                end
                if ((head_reg == id_link) && !nx[LINK_W-1])
                begin
                    state_next = ST_STOP_HS;
                end
                else
                begin
                    state_next = (op_reg == OP_RESTART) ? ST_START : ST_EMIT_OUT;
                end
            end
            ST_STOP_HS:
            begin
                head_start_next = time_rdata;
                state_next      = (op_reg == OP_RESTART) ? ST_START : ST_EMIT_OUT;
            end
            ST_START:
            begin
                if (append_ok)
                begin
                    active_next[id_reg[ENTRY_AW-1:0]] = 1'b1;
                    tail_next = id_link;
                    if (tail_reg[LINK_W-1])
                    begin
                        head_next       = id_link;
                        head_start_next = now_reg;
                    end
                end
                state_next = ST_EMIT_OUT;
            end
            ST_TICK_CHK:
            begin
                if (expire)
                begin
                    active_next[head_reg[ENTRY_AW-1:0]] = 1'b0;
                    n_next     = n_reg + COUNT_W'(1);
                    state_next = ST_TICK_NX;
                end
                else
                begin
                    state_next = (n_reg != '0) ? ST_EMIT_RD : ST_EMIT_OUT;
                end
            end
            ST_TICK_NX:
            begin
                // advance the head; fetch its start time unless the list ran dry
                head_next = nx;
                if (nx[LINK_W-1])
                begin
                    tail_next  = NIL_LINK;
                    state_next = ST_TICK_CHK;
                end
                else
                begin
                    state_next = ST_TICK_HS;
                end
            end
            ST_TICK_HS:
            begin
                head_start_next = time_rdata;
                state_next      = ST_TICK_CHK;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (rsp.ready)
                begin
                    if (out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + COUNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            head_reg    <= NIL_LINK;
            tail_reg    <= NIL_LINK;
            timeout_reg <= TIME_BITS'(1000);
            n_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers: capture the item, hold the single-result fields
    always_ff @(posedge clk)
    begin
        head_start_reg <= head_start_next;
        if (accept)
        begin
            op_reg       <= req.operation;
            id_reg       <= req.entry_id;
            now_reg      <= req.now_time;
            res_kind_reg <= (req.operation == OP_QUERY) ? KIND_QUERY : KIND_ACK;
            res_id_reg   <= (req.operation == OP_QUERY) ? req.entry_id : '0;
            res_act_reg  <= (req.operation == OP_QUERY) &&
                            active_reg[req.entry_id[ENTRY_AW-1:0]];
        end
    end

    assign rsp.valid          = (state_reg == ST_EMIT_OUT);
    assign rsp.kind           = (n_reg != '0) ? KIND_EXPIRED : res_kind_reg;
    assign rsp.expired_id     = (n_reg != '0) ? buf_rdata : res_id_reg;
    assign rsp.entry_active   = (n_reg == '0) && res_act_reg;
    assign rsp.queue_nonempty = !head_reg[LINK_W-1];
    assign rsp.next_deadline  = head_reg[LINK_W-1] ? '0 : (head_start_reg + timeout_reg);
    assign rsp.last           = out_last;

endmodule
